/* src/kvt_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvt_pkg
// shared types and constants of the key/value table engine
// ---------------------------------------------------------------------------
package kvt_pkg;

	localparam int CapacityDef  = 32;
	localparam int ValueBitsDef = 64;
	localparam int KeyW         = 32;
	localparam int ValueW       = 64;
	localparam int CountW       = 6;
	localparam int QueueDepth   = 2;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_LOOKUP  = 2'd1,
		OP_REMOVE  = 2'd2,
		OP_REVERSE = 2'd3
	} op_t;

	// command as classified by the front part
	typedef struct packed {
		op_t               op;
		logic [KeyW-1:0]   key;
		logic [ValueW-1:0] value;
	} cmd_t;

endpackage

/* src/kvt_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvt_ram
// generic single write, single read port ram with registered read
// ---------------------------------------------------------------------------
module kvt_ram #(
	parameter int Width = 8,
	parameter int Depth = 32,
	parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/kvt_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvt_front
// accepts command beats, masks the value and queues them for the back part
// ---------------------------------------------------------------------------
module kvt_front import kvt_pkg::*; #(
	parameter int ValueBits = ValueBitsDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        in_op,
	input  logic [KeyW-1:0]   in_key,
	input  logic [ValueW-1:0] in_value,
	output logic              cmd_valid,
	input  logic              cmd_take,
	output cmd_t              cmd
);

	localparam int PtrW = $clog2(QueueDepth);

	cmd_t            fifo_q [QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [PtrW:0]   cnt_q;
	logic [ValueW-1:0] vmask;
	logic            push;

	always_comb begin
		vmask = '0;
		for (int b = 0; b < ValueW; b++) begin
			if (b < ValueBits) vmask[b] = 1'b1;
		end
	end

	assign in_stall  = (cnt_q == (PtrW+1)'(QueueDepth));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{op: op_t'(in_op), key: in_key, value: in_value & vmask};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (cmd_take) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(cmd_take);
		end
	end

endmodule

/* src/kvt_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvt_back
// sequencer that scans and shifts the table, selects keys in ascending order and emits result beats
// ---------------------------------------------------------------------------
module kvt_back import kvt_pkg::*; #(
	parameter int Capacity  = CapacityDef,
	parameter int ValueBits = ValueBitsDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_take,
	input  cmd_t              cmd,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              hit,
	output logic              full_error,
	output logic [ValueW-1:0] value_out,
	output logic [KeyW-1:0]   key_out,
	output logic [CountW-1:0] pair_count,
	output logic              last
);

	localparam int AW = (Capacity > 1) ? $clog2(Capacity) : 1;
	localparam int NW = $clog2(Capacity + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_ACT, ST_SHIFT, ST_RSEL, ST_OUT
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [NW-1:0]     count_q;
	logic [NW-1:0]     idx_q;     // address issued last cycle
	logic              rd_pend_q;
	logic              found_q;
	logic [AW-1:0]     pos_q;
	logic [ValueW-1:0] fval_q;
	// reverse lookup selection: smallest matching key above prev
	logic              have_prev_q, have_best_q, any_q;
	logic [KeyW-1:0]   prev_q, best_q;

	logic              kwe, vwe;
	logic [AW-1:0]     waddr, raddr;
	logic [KeyW-1:0]   kwdata, krdata;
	logic [ValueW-1:0] vwdata, vrdata;
	logic [NW-1:0]     ridx;
	logic [ValueW-1:0] vmask;
	logic              sel_match, pass_end, ins_new, ins_full, rem_shift;
	logic [KeyW-1:0]   next_key;

	always_comb begin
		vmask = '0;
		for (int b = 0; b < ValueW; b++) begin
			if (b < ValueBits) vmask[b] = 1'b1;
		end
	end

	kvt_ram #(.Width(KeyW), .Depth(Capacity)) u_keys (
		.clk(clk), .we(kwe), .waddr(waddr), .wdata(kwdata),
		.raddr(raddr), .rdata(krdata)
	);
	kvt_ram #(.Width(ValueW), .Depth(Capacity)) u_vals (
		.clk(clk), .we(vwe), .waddr(waddr), .wdata(vwdata),
		.raddr(raddr), .rdata(vrdata)
	);

	assign raddr    = ridx[AW-1:0];
	assign cmd_take = (state_q == ST_IDLE) && cmd_valid;

	assign sel_match = idx_q < count_q && (vrdata & vmask) == cmd_q.value
		&& (!have_prev_q || $signed(krdata) > $signed(prev_q))
		&& (!have_best_q || $signed(krdata) < $signed(best_q));
	assign pass_end  = (idx_q + 1'b1 >= count_q);
	assign next_key  = sel_match ? krdata : best_q;
	assign ins_new   = cmd_q.op == OP_INSERT && !found_q && count_q < NW'(Capacity);
	assign ins_full  = cmd_q.op == OP_INSERT && !found_q && count_q >= NW'(Capacity);
	assign rem_shift = cmd_q.op == OP_REMOVE && found_q && NW'(pos_q) + 1'b1 < count_q;

	// read address: next entry during scan, shift and reverse selection
	always_comb begin
		ridx = '0;
		case (state_q)
			ST_IDLE:  ridx = '0;
			ST_SCAN:  ridx = idx_q + 1'b1;
			// wrap to entry zero for the next selection pass
			ST_RSEL:  ridx = pass_end ? '0 : idx_q + 1'b1;
			ST_ACT:   ridx = NW'(pos_q) + 1'b1;
			ST_SHIFT: ridx = idx_q + 1'b1;
			default:  ridx = '0;
		endcase
		if (ridx >= NW'(Capacity)) ridx = '0;
	end

	// write port: insert/update in ACT, gap closing in SHIFT
	always_comb begin
		kwe    = 1'b0;
		vwe    = 1'b0;
		waddr  = pos_q;
		kwdata = cmd_q.key;
		vwdata = cmd_q.value;
		case (state_q)
			ST_ACT: begin
				if (cmd_q.op == OP_INSERT) begin
					if (found_q) begin
						vwe = 1'b1;
					end else if (count_q < NW'(Capacity)) begin
						kwe   = 1'b1;
						vwe   = 1'b1;
						waddr = count_q[AW-1:0];
					end
				end
			end
			ST_SHIFT: begin
				if (rd_pend_q) begin
					kwe    = 1'b1;
					vwe    = 1'b1;
					waddr  = AW'(idx_q - 1'b1);
					kwdata = krdata;
					vwdata = vrdata;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid   <= 1'b0;
			idx_q       <= '0;
			rd_pend_q   <= 1'b0;
			found_q     <= 1'b0;
			any_q       <= 1'b0;
			have_prev_q <= 1'b0;
			have_best_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q       <= cmd;
						idx_q       <= '0;
						rd_pend_q   <= 1'b1;
						found_q     <= 1'b0;
						any_q       <= 1'b0;
						have_prev_q <= 1'b0;
						have_best_q <= 1'b0;
						state_q     <= (cmd.op == OP_REVERSE) ? ST_RSEL : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// data for idx_q is on the ram outputs now
					if (idx_q < count_q && !found_q && krdata == cmd_q.key) begin
						found_q <= 1'b1;
						pos_q   <= idx_q[AW-1:0];
						fval_q  <= vrdata;
					end
					if (idx_q + 1'b1 >= count_q) begin
						state_q <= ST_ACT;
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_ACT: begin
					hit        <= (cmd_q.op == OP_INSERT) ? ins_new : found_q;
					full_error <= ins_full;
					value_out  <= (cmd_q.op == OP_LOOKUP && found_q) ? (fval_q & vmask) : '0;
					key_out    <= '0;
					last       <= 1'b1;
					if (ins_new) begin
						count_q <= count_q + 1'b1;
					end else if (cmd_q.op == OP_REMOVE && found_q && !rem_shift) begin
						count_q <= count_q - 1'b1;
					end
					if (rem_shift) begin
						// entry pos+1 is being read this cycle
						idx_q   <= NW'(pos_q) + 1'b1;
						state_q <= ST_SHIFT;
					end else begin
						out_valid <= 1'b1;
						state_q   <= ST_OUT;
					end
				end
				ST_SHIFT: begin
					if (idx_q + 1'b1 >= count_q) begin
						count_q   <= count_q - 1'b1;
						out_valid <= 1'b1;
						state_q   <= ST_OUT;
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_RSEL: begin
					// one pass finds the next key in ascending order
					if (!pass_end) begin
						idx_q <= idx_q + 1'b1;
						if (sel_match) begin
							have_best_q <= 1'b1;
							best_q      <= krdata;
						end
					end else begin
						idx_q       <= '0;
						have_best_q <= 1'b0;
						full_error  <= 1'b0;
						value_out   <= '0;
						if (sel_match || have_best_q) begin
							// found next key: if one is pending, emit pending (not last)
							any_q       <= 1'b1;
							have_prev_q <= 1'b1;
							prev_q      <= next_key;
							if (any_q) begin
								key_out   <= prev_q;
								hit       <= 1'b1;
								last      <= 1'b0;
								out_valid <= 1'b1;
								state_q   <= ST_OUT;
							end
						end else begin
							hit       <= any_q;
							key_out   <= any_q ? prev_q : '0;
							last      <= 1'b1;
							out_valid <= 1'b1;
							state_q   <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						if (cmd_q.op == OP_REVERSE && !last) begin
							idx_q       <= '0;
							have_best_q <= 1'b0;
							state_q     <= ST_RSEL;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign pair_count = CountW'(count_q);

endmodule

/* src/key_value_table_engine_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_value_table_engine_top
// table of unique signed keys with value words, linear search engine
// ---------------------------------------------------------------------------
// usage:
//   command beats (op, key, value) enter on in_valid/in_stall into a two
//   entry queue; the back sequencer takes one command at a time.
//   result beats leave on out_valid/out_stall, one per command, or one per
//   matching key for a reverse lookup, with last on the final beat.
// sequencing:
//   insert / lookup: one scan of the stored pairs, then the action; remove
//   adds gap closing through the single ram write port.
//   reverse lookup: one full scan of the table per emitted key plus one.
// reset: the pair count clears, the table contents stay undefined and are
//   never read beyond the count. a stalled result holds and the sequencer
//   waits; commands keep queuing until the queue is full.
// ---------------------------------------------------------------------------
module key_value_table_engine_top import kvt_pkg::*; #(
	parameter int Capacity  = CapacityDef,
	parameter int ValueBits = ValueBitsDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic [KeyW-1:0]   key,
	input  logic [ValueW-1:0] value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              hit,
	output logic              full_error,
	output logic [ValueW-1:0] value_out,
	output logic [KeyW-1:0]   key_out,
	output logic [CountW-1:0] pair_count,
	output logic              last
);

	logic cmd_valid, cmd_take;
	cmd_t cmd;

	kvt_front #(.ValueBits(ValueBits)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_op(op), .in_key(key), .in_value(value),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	kvt_back #(.Capacity(Capacity), .ValueBits(ValueBits)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd(cmd), .out_valid(out_valid), .out_stall(out_stall), .hit(hit),
		.full_error(full_error), .value_out(value_out), .key_out(key_out),
		.pair_count(pair_count), .last(last)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		pair_count <= CountW'(Capacity))
		else $error("pair count above capacity");

	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && full_error |-> !hit && pair_count == CountW'(Capacity))
		else $error("full error with hit or free room");

	a_take_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid)
		else $error("command taken from empty queue");

endmodule
